@@ rtl/core/contiguous_page_bitmap_allocator_unit_defines.svh @@
// Assertion macros for the page bitmap allocator.
// Taken in by every RTL file that carries concurrent checks; no other dependency.
`ifndef CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define CPBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpba check failed");
// Next-cycle implication, disabled during reset.
`define CPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpba check failed");
`else
`define CPBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/cpba_pkg.sv @@
// Shared types and constants for the page bitmap allocator.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package cpba_pkg;

  localparam int unsigned PAGE_COUNT_DEF = 1024;
  localparam int unsigned RUN_LIMIT      = 64;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_COUNT = 2'd1,
    STATUS_NO_SPACE  = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_REGION_START = 2'd0;
  localparam cfg_index_t CFG_REGION_END   = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_FOUND,
    ST_MARK_LO,
    ST_MARK_HI,
    ST_FREE_LO,
    ST_FREE_HI,
    ST_DONE
  } state_t;

  // Ones in the low count bits.
  function automatic logic [63:0] run_mask(input logic [5:0] count);
    return (64'd1 << count) - 64'd1;
  endfunction

endpackage

@@ rtl/core/cpba_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module cpba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/contiguous_page_bitmap_allocator_unit.sv @@
// First-fit contiguous page allocator over a one-bit-per-page used map.
//
// Request channel s_*: one item per request, kind in s_tuser (allocate or free),
// page_count and page_index in s_tdata. Result channel m_*: one item per request
// with status, first_page and the pages still free in the region.
// Config channel cfg_*: region_start (index 0) and region_end (index 1), always
// ready; write it only while no request is in flight.
//
// The used map lives in a RAM of 64-bit words (PAGE_COUNT/64 words) with a
// registered read. An allocate reads the region word by word and tests every
// start position of the current word against the word and its upper neighbor.
// A free reads, clears and writes back at most two words. A rejected request
// goes straight from the start state to the result.
// One request is handled at a time; the next is taken once the result sits in
// the output register, so a stalled receiver holds at most one result before
// the block waits on it.
// After reset the block zeroes the map word by word and takes no request during
// that time; config writes are taken throughout.
`timescale 1ns / 1ps
`include "contiguous_page_bitmap_allocator_unit_defines.svh"

module contiguous_page_bitmap_allocator_unit #(
  parameter int unsigned PAGE_COUNT = cpba_pkg::PAGE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,    // [5:0] page_count, [15:6] page_index
  input  logic [0:0]           s_tuser,    // [0] kind
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,    // [1:0] status, [11:2] first_page,
                                           // [22:12] avail_pages, [23] zero
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cpba_pkg::cfg_index_t cfg_index,
  input  logic [10:0]          cfg_data
);

  import cpba_pkg::*;

  localparam int unsigned MAP_WORDS = (PAGE_COUNT + 63) / 64;
  localparam int unsigned MA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned WW        = $clog2(MAP_WORDS + 3);
  localparam int unsigned EW        = $clog2(PAGE_COUNT + 1);
  localparam int unsigned VW        = ((EW > 11) ? EW : 11) + 1;

  state_t state, state_next;

  // request item
  kind_t      kind;
  logic [5:0] count;
  logic [9:0] index;

  logic [9:0]  region_start;
  logic [10:0] region_end;
  logic [EW-1:0] used_pages;

  // scan pipeline
  logic [WW-1:0] scan_word, cur_word, hit_word;
  logic [63:0]   cur, hit_lo, hit_hi, hit_vec;
  logic          have_cur, hit_valid;
  logic [5:0]    first_bit;
  status_t       status;
  logic [9:0]    first_page;

  // output register
  status_t     out_status;
  logic [9:0]  out_first;
  logic [10:0] out_free;

  // map RAM
  logic            ram_we;
  logic [MA_W-1:0] ram_waddr, ram_raddr;
  logic [63:0]     ram_wdata, ram_q;

  // region arithmetic
  logic [VW-1:0] rs_v, re_v, pc_v, e_clip, size_v, used_v, free_v, count_v, index_v;
  logic [VW-1:0] last_v, alloc_page;
  logic [WW-1:0] rs_word, e_word, last_word, idx_word;
  logic [5:0]    rs_bit, e_bit, mask_pos;
  logic          bad_count;
  status_t       start_status;

  logic [127:0] free_win, acc, run128;
  logic [127:0] pw [6];
  logic [63:0]  cand, mask_lo, mask_hi;
  logic         hit_now, scan_miss;
  logic [WW+15:0] page_ext;

  function automatic logic [MA_W-1:0] word_addr(input logic [WW-1:0] w);
    if (w < WW'(MAP_WORDS)) begin
      return w[MA_W-1:0];
    end
    return '0;
  endfunction

  // Pages of word x that lie inside [region_start, clipped end).
  function automatic logic [63:0] region_mask(input logic [WW-1:0] x,
                                              input logic [WW-1:0] sw,
                                              input logic [5:0]    sb,
                                              input logic [WW-1:0] ew,
                                              input logic [5:0]    eb);
    logic [63:0] ge, lt;
    if (x < sw) begin
      ge = '0;
    end else if (x == sw) begin
      ge = ~64'd0 << sb;
    end else begin
      ge = ~64'd0;
    end
    if (x < ew) begin
      lt = ~64'd0;
    end else if (x == ew) begin
      lt = (64'd1 << eb) - 64'd1;
    end else begin
      lt = '0;
    end
    return ge & lt;
  endfunction

  function automatic logic [5:0] lowest_set(input logic [63:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

  cpba_ram #(
    .WIDTH (64),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, out_free, out_first, out_status};

  assign rs_v    = VW'(region_start);
  assign re_v    = VW'(region_end);
  assign pc_v    = VW'(PAGE_COUNT);
  assign e_clip  = (re_v > pc_v) ? pc_v : re_v;
  assign size_v  = (rs_v < e_clip) ? e_clip - rs_v : '0;
  assign used_v  = VW'(used_pages);
  assign free_v  = (used_v < size_v) ? size_v - used_v : '0;
  assign count_v = VW'(count);
  assign index_v = VW'(index);
  assign last_v  = e_clip - VW'(1);

  assign rs_word   = rs_v[WW+5:6];
  assign rs_bit    = rs_v[5:0];
  assign e_word    = e_clip[WW+5:6];
  assign e_bit     = e_clip[5:0];
  assign last_word = last_v[WW+5:6];
  assign idx_word  = index_v[WW+5:6];

  assign bad_count = (count == 6'd0) || (32'(count) >= RUN_LIMIT);

  always_comb begin
    if (bad_count) begin
      start_status = STATUS_BAD_COUNT;
    end else if (kind == KIND_ALLOC && free_v < count_v) begin
      start_status = STATUS_NO_SPACE;
    end else if (kind == KIND_FREE && index_v + count_v > pc_v) begin
      start_status = STATUS_RANGE;
    end else begin
      start_status = STATUS_OK;
    end
  end

  // Free pages of the current word and its upper neighbor, outside region masked.
  assign free_win = {~ram_q & region_mask(WW'(cur_word + 1'b1), rs_word, rs_bit,
                                          e_word, e_bit),
                     ~cur & region_mask(cur_word, rs_word, rs_bit, e_word, e_bit)};

  // pw[k][b]: 2^k free pages start at b. Combine the levels named by count's bits.
  always_comb begin
    pw[0] = free_win;
    for (int k = 1; k < 6; k++) begin
      pw[k] = pw[k-1] & (pw[k-1] >> (1 << (k - 1)));
    end
    acc = '1;
    for (int k = 0; k < 6; k++) begin
      if (count[k]) begin
        acc = acc & (pw[k] >> (count & 6'((1 << k) - 1)));
      end
    end
    cand = acc[63:0];
  end

  assign hit_now   = hit_valid && (hit_vec != '0);
  assign scan_miss = hit_valid && (hit_vec == '0) && (hit_word == last_word);

  assign mask_pos = (kind == KIND_ALLOC) ? first_bit : index[5:0];
  assign run128   = {64'd0, run_mask(count)} << mask_pos;
  assign mask_lo  = run128[63:0];
  assign mask_hi  = run128[127:64];

  assign alloc_page = VW'({hit_word, first_bit});
  assign page_ext   = {10'd0, hit_word, first_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = word_addr(scan_word);
        if (scan_word == WW'(MAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (start_status != STATUS_OK) begin
          state_next = ST_DONE;
        end else if (kind == KIND_ALLOC) begin
          ram_raddr  = word_addr(rs_word);
          state_next = ST_SCAN;
        end else begin
          ram_raddr  = word_addr(idx_word);
          state_next = ST_FREE_LO;
        end
      end
      ST_SCAN: begin
        ram_raddr = word_addr(WW'(scan_word + 1'b1));
        if (hit_now) begin
          state_next = ST_FOUND;
        end else if (scan_miss) begin
          state_next = ST_DONE;
        end
      end
      ST_FOUND: begin
        state_next = ST_MARK_LO;
      end
      ST_MARK_LO: begin
        ram_we     = 1'b1;
        ram_waddr  = word_addr(hit_word);
        ram_wdata  = hit_lo | mask_lo;
        state_next = ST_MARK_HI;
      end
      ST_MARK_HI: begin
        ram_we     = (mask_hi != '0);
        ram_waddr  = word_addr(WW'(hit_word + 1'b1));
        ram_wdata  = hit_hi | mask_hi;
        state_next = ST_DONE;
      end
      ST_FREE_LO: begin
        ram_we     = 1'b1;
        ram_waddr  = word_addr(idx_word);
        ram_wdata  = ram_q & ~mask_lo;
        ram_raddr  = word_addr(WW'(idx_word + 1'b1));
        state_next = ST_FREE_HI;
      end
      ST_FREE_HI: begin
        ram_we     = (mask_hi != '0);
        ram_waddr  = word_addr(WW'(idx_word + 1'b1));
        ram_wdata  = ram_q & ~mask_hi;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= 11'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REGION_START: region_start <= cfg_data[9:0];
        CFG_REGION_END:   region_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_word  <= '0;
      have_cur   <= 1'b0;
      hit_valid  <= 1'b0;
      used_pages <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          scan_word <= WW'(scan_word + 1'b1);
        end
        ST_START: begin
          scan_word <= rs_word;
          have_cur  <= 1'b0;
          hit_valid <= 1'b0;
        end
        ST_SCAN: begin
          // hold the hit registers once a decision is due
          if (!hit_now && !scan_miss) begin
            scan_word <= WW'(scan_word + 1'b1);
            have_cur  <= 1'b1;
            if (have_cur) begin
              hit_valid <= 1'b1;
            end
          end
        end
        ST_MARK_HI: begin
          used_pages <= used_pages + EW'(count);
        end
        ST_FREE_HI: begin
          used_pages <= (used_pages > EW'(count)) ? used_pages - EW'(count) : '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      kind  <= kind_t'(s_tuser[0]);
      count <= s_tdata[5:0];
      index <= s_tdata[15:6];
    end
    if (state == ST_START) begin
      status     <= start_status;
      first_page <= '0;
    end
    if (state == ST_SCAN && !hit_now && !scan_miss) begin
      cur      <= ram_q;
      cur_word <= scan_word;
      if (have_cur) begin
        hit_vec  <= cand;
        hit_word <= cur_word;
        hit_lo   <= cur;
        hit_hi   <= ram_q;
      end
    end
    if (state == ST_SCAN && scan_miss) begin
      status <= STATUS_NO_SPACE;
    end
    if (state == ST_FOUND) begin
      first_bit <= lowest_set(hit_vec);
    end
    if (state == ST_MARK_HI) begin
      first_page <= page_ext[9:0];
    end
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      out_status <= status;
      out_first  <= first_page;
      out_free   <= free_v[10:0];
    end
  end

  `CPBA_ASSERT_IMPLY(a_used_bound, clk, rst, 1'b1, used_v <= pc_v)
  `CPBA_ASSERT_IMPLY(a_alloc_in_region, clk, rst, state == ST_MARK_LO,
                     alloc_page >= rs_v && alloc_page + count_v <= e_clip)
  `CPBA_ASSERT_IMPLY(a_hi_word_in_map, clk, rst, state == ST_MARK_HI && mask_hi != '0,
                     hit_word < WW'(MAP_WORDS - 1))
  `CPBA_ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready, state == ST_START)
  `CPBA_ASSERT_NEXT(a_result_loaded, clk, rst, state == ST_DONE && (!m_tvalid || m_tready),
                    m_tvalid && state == ST_IDLE)

endmodule
